[hdl/fap_pkg.sv]
// Shared types and constants for the fixed-partition allocator.
`default_nettype none

package fap_pkg;

	localparam int BLOCK_INDEX_W = 4;
	localparam int SIZE_W        = 16;
	localparam int FRAG_W        = 20;
	localparam int CFG_INDEX_W   = 1;
	localparam int CFG_DATA_W    = 5;

	localparam logic [FRAG_W-1:0] FRAG_MAX = {FRAG_W{1'b1}};

	localparam logic [CFG_INDEX_W-1:0] REG_BLOCKS_IN_USE = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] REG_POLICY        = 1'b1;

	localparam logic [4:0] BLOCKS_IN_USE_RESET = 5'd16;

	typedef enum logic [1:0] {
		OP_LOAD   = 2'd0,
		OP_CLEAR  = 2'd1,
		OP_ALLOC  = 2'd2,
		OP_REPORT = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		POL_FIRST = 2'd0,
		POL_BEST  = 2'd1,
		POL_WORST = 2'd2,
		POL_NEXT  = 2'd3
	} policy_t;

	// Control half of the scan item that walks down the cell row.
	typedef struct packed {
		logic valid;
		logic alloc;
		logic best_found;
		logic nf_found;
	} scan_ctrl_t;

	// Commands broadcast from the controller to every cell.
	typedef struct packed {
		logic load;
		logic clear;
		logic grant;
	} cell_cmd_t;

endpackage

`default_nettype wire

[hdl/fap_cell.sv]
// One partition cell: holds a block's sizes and used bit and updates the passing scan item.
`default_nettype none

module fap_cell #(
	parameter int IDX       = 0,
	parameter int IDX_W     = 4,
	parameter int CNT_W     = 5,
	parameter int SIZE_BITS = 16,
	parameter int SUM_W     = 20
) (
	input  wire                                    clk,
	input  wire                                    arst_n,
	input  fap_pkg::cell_cmd_t                     cmd,
	input  wire [fap_pkg::BLOCK_INDEX_W-1:0]       load_index,
	input  wire [SIZE_BITS-1:0]                    load_size,
	input  wire [IDX_W-1:0]                        grant_index,
	input  fap_pkg::policy_t                       policy,
	input  wire [CNT_W-1:0]                        active_count,
	input  wire [IDX_W-1:0]                        start_index,
	input  wire [SIZE_BITS-1:0]                    req_size,
	input  fap_pkg::scan_ctrl_t                    ctrl_in,
	input  wire [IDX_W-1:0]                        best_idx_in,
	input  wire [SIZE_BITS-1:0]                    best_rem_in,
	input  wire [IDX_W-1:0]                        nf_idx_in,
	input  wire [SUM_W-1:0]                        inner_in,
	input  wire [SUM_W-1:0]                        outer_in,
	output fap_pkg::scan_ctrl_t                    ctrl_s1,
	output logic [IDX_W-1:0]                       best_idx_s1,
	output logic [SIZE_BITS-1:0]                   best_rem_s1,
	output logic [IDX_W-1:0]                       nf_idx_s1,
	output logic [SUM_W-1:0]                       inner_s1,
	output logic [SUM_W-1:0]                       outer_s1
);

	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);
	localparam logic [CNT_W-1:0] MY_CNT = CNT_W'(IDX);

	logic [SIZE_BITS-1:0] orig_q;
	logic [SIZE_BITS-1:0] rem_q;
	logic                 used_q;

	logic active;
	logic load_hit;
	logic grant_hit;
	logic fit;
	logic take_best;
	logic take_nf;

	assign active    = MY_CNT < active_count;
	assign load_hit  = int'(load_index) == IDX;
	assign grant_hit = grant_index == MY_IDX;
	assign fit       = active && !used_q && (rem_q >= req_size);

	always_comb begin
		unique case (policy)
			fap_pkg::POL_FIRST, fap_pkg::POL_NEXT: begin
				take_best = fit && !ctrl_in.best_found;
			end
			fap_pkg::POL_BEST: begin
				take_best = fit && (!ctrl_in.best_found || rem_q < best_rem_in);
			end
			fap_pkg::POL_WORST: begin
				take_best = fit && (!ctrl_in.best_found || rem_q > best_rem_in);
			end
			default: begin
				take_best = 1'b0;
			end
		endcase
		// Next fit also tracks the first fitting block at or after the start pointer.
		take_nf = (policy == fap_pkg::POL_NEXT) && fit && !ctrl_in.nf_found &&
			(MY_IDX >= start_index);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= 1'b0;
		end else if (cmd.clear) begin
			used_q <= 1'b0;
		end else if (cmd.grant && grant_hit) begin
			used_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load && load_hit) begin
			orig_q <= load_size;
			rem_q  <= load_size;
		end else if (cmd.clear) begin
			rem_q <= orig_q;
		end else if (cmd.grant && grant_hit) begin
			rem_q <= rem_q - req_size;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1 <= '0;
		end else begin
			ctrl_s1.valid      <= ctrl_in.valid;
			ctrl_s1.alloc      <= ctrl_in.alloc;
			ctrl_s1.best_found <= ctrl_in.best_found || (ctrl_in.alloc && take_best);
			ctrl_s1.nf_found   <= ctrl_in.nf_found || (ctrl_in.alloc && take_nf);
		end
	end

	always_ff @(posedge clk) begin
		best_idx_s1 <= best_idx_in;
		best_rem_s1 <= best_rem_in;
		nf_idx_s1   <= nf_idx_in;
		inner_s1    <= inner_in;
		outer_s1    <= outer_in;
		if (ctrl_in.alloc) begin
			if (take_best) begin
				best_idx_s1 <= MY_IDX;
				best_rem_s1 <= rem_q;
			end
			if (take_nf) begin
				nf_idx_s1 <= MY_IDX;
			end
		end else if (active) begin
			if (used_q) begin
				inner_s1 <= inner_in + SUM_W'(rem_q);
			end else begin
				outer_s1 <= outer_in + SUM_W'(rem_q);
			end
		end
	end

endmodule

`default_nettype wire

[hdl/fixed_partition_allocator_core.sv]
// Top level of the fixed-partition allocator: controller, configuration and the cell row.
// Load and clear take effect at the accepting edge; done is high in the next cycle and
// start is taken again right away.
// Allocate and report send one scan item down the row of NUM_BLOCKS cells, one cell per
// cycle, through launch_q, the cell registers and done_q; busy falls as done rises and
// start is not taken while busy. Results cannot be stalled.
// Reset clears used bits, the next-fit pointer, failure record and busy; sizes are unset.
`default_nettype none

module fixed_partition_allocator_core #(
	parameter int NUM_BLOCKS = 16,
	parameter int SIZE_BITS  = 16
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  start,
	output logic                                 busy,
	input  wire [1:0]                            op,
	input  wire [fap_pkg::BLOCK_INDEX_W-1:0]     block_index,
	input  wire [fap_pkg::SIZE_W-1:0]            size,
	input  wire                                  cfg_we,
	input  wire [fap_pkg::CFG_INDEX_W-1:0]       cfg_index,
	input  wire [fap_pkg::CFG_DATA_W-1:0]        cfg_data,
	output logic                                 done,
	output logic                                 granted,
	output logic [fap_pkg::BLOCK_INDEX_W-1:0]    block_granted,
	output logic [fap_pkg::FRAG_W-1:0]           internal_frag,
	output logic [fap_pkg::FRAG_W-1:0]           external_frag,
	output logic                                 has_failed,
	output logic [fap_pkg::SIZE_W-1:0]           failed_size,
	output logic                                 fits_despite_free
);

	localparam int IDX_W = $clog2(NUM_BLOCKS);
	localparam int CNT_W = $clog2(NUM_BLOCKS + 1);
	localparam int SUM_W = SIZE_BITS + IDX_W;
	localparam int EXT_W = (SUM_W > fap_pkg::FRAG_W) ? SUM_W : fap_pkg::FRAG_W;
	localparam int MW    = (CNT_W > fap_pkg::CFG_DATA_W) ? CNT_W : fap_pkg::CFG_DATA_W;

	// Configuration and controller state.
	logic [4:0]           blocks_in_use_q;
	fap_pkg::policy_t     policy_q;
	logic                 busy_q;
	fap_pkg::scan_ctrl_t  launch_q;
	logic                 done_q;
	logic [IDX_W-1:0]     next_ptr_q;
	logic                 failed_valid_q;
	logic [SIZE_BITS-1:0] failed_size_q;
	logic [SIZE_BITS-1:0] req_q;
	logic [IDX_W-1:0]     start_q;

	// Result registers.
	logic                              granted_q;
	logic [fap_pkg::BLOCK_INDEX_W-1:0] block_granted_q;
	logic [fap_pkg::FRAG_W-1:0]        internal_frag_q;
	logic [fap_pkg::FRAG_W-1:0]        external_frag_q;
	logic                              has_failed_q;
	logic [fap_pkg::SIZE_W-1:0]        failed_size_out_q;
	logic                              fits_q;

	// Scan chain, position k feeds cell k.
	fap_pkg::scan_ctrl_t  ctrl_c     [NUM_BLOCKS+1];
	logic [IDX_W-1:0]     best_idx_c [NUM_BLOCKS+1];
	logic [SIZE_BITS-1:0] best_rem_c [NUM_BLOCKS+1];
	logic [IDX_W-1:0]     nf_idx_c   [NUM_BLOCKS+1];
	logic [SUM_W-1:0]     inner_c    [NUM_BLOCKS+1];
	logic [SUM_W-1:0]     outer_c    [NUM_BLOCKS+1];
	logic [NUM_BLOCKS:0]  valid_vec;

	fap_pkg::op_t         op_in;
	fap_pkg::cell_cmd_t   cmd;
	logic                 accept;
	logic [MW-1:0]        bu_ext;
	logic [CNT_W-1:0]     active_count;
	logic [SIZE_BITS-1:0] size_in;
	logic                 exit_valid;
	logic                 exit_alloc;
	logic                 exit_found;
	logic [IDX_W-1:0]     exit_idx;
	logic [EXT_W-1:0]     inner_ext;
	logic [EXT_W-1:0]     outer_ext;
	logic [fap_pkg::FRAG_W-1:0] inner_sat;
	logic [fap_pkg::FRAG_W-1:0] outer_sat;

	assign op_in   = fap_pkg::op_t'(op);
	assign accept  = start && !busy_q;
	assign size_in = SIZE_BITS'(size);

	assign bu_ext       = MW'(blocks_in_use_q);
	assign active_count = (bu_ext > MW'(NUM_BLOCKS)) ? CNT_W'(NUM_BLOCKS) : CNT_W'(bu_ext);

	assign exit_valid = ctrl_c[NUM_BLOCKS].valid;
	assign exit_alloc = ctrl_c[NUM_BLOCKS].alloc;

	always_comb begin
		// For next fit the best slot holds the first fitting block overall, which is the
		// wrap-around choice when nothing fits at or after the pointer.
		if (policy_q == fap_pkg::POL_NEXT) begin
			exit_found = ctrl_c[NUM_BLOCKS].nf_found || ctrl_c[NUM_BLOCKS].best_found;
			exit_idx   = ctrl_c[NUM_BLOCKS].nf_found ? nf_idx_c[NUM_BLOCKS]
				: best_idx_c[NUM_BLOCKS];
		end else begin
			exit_found = ctrl_c[NUM_BLOCKS].best_found;
			exit_idx   = best_idx_c[NUM_BLOCKS];
		end
		inner_ext = EXT_W'(inner_c[NUM_BLOCKS]);
		outer_ext = EXT_W'(outer_c[NUM_BLOCKS]);
		inner_sat = (inner_ext > EXT_W'(fap_pkg::FRAG_MAX)) ? fap_pkg::FRAG_MAX
			: inner_ext[fap_pkg::FRAG_W-1:0];
		outer_sat = (outer_ext > EXT_W'(fap_pkg::FRAG_MAX)) ? fap_pkg::FRAG_MAX
			: outer_ext[fap_pkg::FRAG_W-1:0];
		cmd.load  = accept && (op_in == fap_pkg::OP_LOAD);
		cmd.clear = accept && (op_in == fap_pkg::OP_CLEAR);
		cmd.grant = exit_valid && exit_alloc && exit_found;
	end

	assign ctrl_c[0]     = launch_q;
	assign best_idx_c[0] = '0;
	assign best_rem_c[0] = '0;
	assign nf_idx_c[0]   = '0;
	assign inner_c[0]    = '0;
	assign outer_c[0]    = '0;

	genvar g;
	generate
		for (g = 0; g < NUM_BLOCKS; g++) begin : g_cell
			fap_cell #(
				.IDX       (g),
				.IDX_W     (IDX_W),
				.CNT_W     (CNT_W),
				.SIZE_BITS (SIZE_BITS),
				.SUM_W     (SUM_W)
			) u_cell (
				.clk          (clk),
				.arst_n       (arst_n),
				.cmd          (cmd),
				.load_index   (block_index),
				.load_size    (size_in),
				.grant_index  (exit_idx),
				.policy       (policy_q),
				.active_count (active_count),
				.start_index  (start_q),
				.req_size     (req_q),
				.ctrl_in      (ctrl_c[g]),
				.best_idx_in  (best_idx_c[g]),
				.best_rem_in  (best_rem_c[g]),
				.nf_idx_in    (nf_idx_c[g]),
				.inner_in     (inner_c[g]),
				.outer_in     (outer_c[g]),
				.ctrl_s1      (ctrl_c[g+1]),
				.best_idx_s1  (best_idx_c[g+1]),
				.best_rem_s1  (best_rem_c[g+1]),
				.nf_idx_s1    (nf_idx_c[g+1]),
				.inner_s1     (inner_c[g+1]),
				.outer_s1     (outer_c[g+1])
			);
		end
		for (g = 0; g <= NUM_BLOCKS; g++) begin : g_valid
			assign valid_vec[g] = ctrl_c[g].valid;
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blocks_in_use_q <= fap_pkg::BLOCKS_IN_USE_RESET;
			policy_q        <= fap_pkg::POL_FIRST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				fap_pkg::REG_BLOCKS_IN_USE: begin
					blocks_in_use_q <= cfg_data;
				end
				fap_pkg::REG_POLICY: begin
					policy_q <= fap_pkg::policy_t'(cfg_data[1:0]);
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q         <= 1'b0;
			launch_q       <= '0;
			done_q         <= 1'b0;
			next_ptr_q     <= '0;
			failed_valid_q <= 1'b0;
			failed_size_q  <= '0;
		end else begin
			launch_q <= '0;
			done_q   <= exit_valid || cmd.load || cmd.clear;
			if (accept && (op_in == fap_pkg::OP_ALLOC || op_in == fap_pkg::OP_REPORT)) begin
				busy_q         <= 1'b1;
				launch_q.valid <= 1'b1;
				launch_q.alloc <= op_in == fap_pkg::OP_ALLOC;
			end else if (exit_valid) begin
				busy_q <= 1'b0;
			end
			if (cmd.clear) begin
				next_ptr_q     <= '0;
				failed_valid_q <= 1'b0;
				failed_size_q  <= '0;
			end else if (exit_valid && exit_alloc) begin
				if (exit_found) begin
					if (policy_q == fap_pkg::POL_NEXT) begin
						next_ptr_q <= exit_idx;
					end
				end else if (!failed_valid_q) begin
					failed_valid_q <= 1'b1;
					failed_size_q  <= req_q;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q   <= size_in;
			start_q <= (CNT_W'(next_ptr_q) < active_count) ? next_ptr_q : '0;
			granted_q         <= 1'b0;
			block_granted_q   <= '0;
			internal_frag_q   <= '0;
			external_frag_q   <= '0;
			has_failed_q      <= 1'b0;
			failed_size_out_q <= '0;
			fits_q            <= 1'b0;
		end else if (exit_valid) begin
			if (exit_alloc) begin
				granted_q       <= exit_found;
				block_granted_q <= exit_found ? fap_pkg::BLOCK_INDEX_W'(exit_idx) : '0;
			end else begin
				internal_frag_q   <= inner_sat;
				external_frag_q   <= outer_sat;
				has_failed_q      <= failed_valid_q;
				failed_size_out_q <= failed_valid_q ? fap_pkg::SIZE_W'(failed_size_q) : '0;
				fits_q            <= failed_valid_q &&
					(outer_c[NUM_BLOCKS] >= SUM_W'(failed_size_q));
			end
		end
	end

	assign busy              = busy_q;
	assign done              = done_q;
	assign granted           = granted_q;
	assign block_granted     = block_granted_q;
	assign internal_frag     = internal_frag_q;
	assign external_frag     = external_frag_q;
	assign has_failed        = has_failed_q;
	assign failed_size       = failed_size_out_q;
	assign fits_despite_free = fits_q;

	a_single_item: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_vec) <= 1)
		else $error("more than one scan item in the cell row");

	a_idle_row_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> (valid_vec == '0))
		else $error("scan item present while not busy");

	a_grant_after_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && granted_q) |-> $fell(busy_q))
		else $error("grant reported without a finished scan");

	a_grant_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && granted_q) |-> !busy_q)
		else $error("grant reported while a scan is running");

	a_exit_busy: assert property (@(posedge clk) disable iff (!arst_n)
		exit_valid |-> busy_q)
		else $error("scan item left the row while not busy");

endmodule

`default_nettype wire

[sim/tb_fixed_partition_allocator_core.sv]
// Self-checking testbench for the fixed-partition allocator core under all four fit policies.
`timescale 1ns / 1ps

module tb_fixed_partition_allocator_core;
	import fap_pkg::*;

	localparam int NUM_PARTS   = 16;
	localparam int STALL_LIMIT = 2000;
	localparam int ITEM_TARGET = 1150;
	localparam int PRINT_LIMIT = 60;

	typedef struct {
		logic              granted;
		logic [3:0]        block;
		logic [FRAG_W-1:0] internal;
		logic [FRAG_W-1:0] external;
		logic              failed;
		logic [SIZE_W-1:0] failed_req;
		logic              fits_free;
	} outcome_t;

	logic                     clk         = 1'b0;
	logic                     arst_n      = 1'b0;
	logic                     start       = 1'b0;
	logic [1:0]               op          = '0;
	logic [BLOCK_INDEX_W-1:0] block_index = '0;
	logic [SIZE_W-1:0]        size        = '0;
	logic                     cfg_we      = 1'b0;
	logic [CFG_INDEX_W-1:0]   cfg_index   = '0;
	logic [CFG_DATA_W-1:0]    cfg_data    = '0;
	logic                     busy;
	logic                     done;
	logic                     granted;
	logic [BLOCK_INDEX_W-1:0] block_granted;
	logic [FRAG_W-1:0]        internal_frag;
	logic [FRAG_W-1:0]        external_frag;
	logic                     has_failed;
	logic [SIZE_W-1:0]        failed_size;
	logic                     fits_despite_free;

	// Predicted allocator state and configuration.
	logic [SIZE_W-1:0] part_orig [NUM_PARTS];
	logic [SIZE_W-1:0] part_rem [NUM_PARTS];
	logic              part_used [NUM_PARTS];
	logic [3:0]        nf_ptr;
	logic              fail_seen;
	logic [SIZE_W-1:0] fail_req;
	logic [4:0]        cfg_count;
	policy_t           cfg_policy;

	outcome_t outcome_q[$];
	int       mismatches   = 0;
	int       items_sent   = 0;
	int       stall_cycles = 0;
	logic     start_held   = 1'b0;
	logic     no_idle      = 1'b0;

	fixed_partition_allocator_core #(
		.NUM_BLOCKS(NUM_PARTS),
		.SIZE_BITS (SIZE_W)
	) DUT (
		.clk              (clk),
		.arst_n           (arst_n),
		.start            (start),
		.busy             (busy),
		.op               (op),
		.block_index      (block_index),
		.size             (size),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.done             (done),
		.granted          (granted),
		.block_granted    (block_granted),
		.internal_frag    (internal_frag),
		.external_frag    (external_frag),
		.has_failed       (has_failed),
		.failed_size      (failed_size),
		.fits_despite_free(fits_despite_free)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	task automatic report_mismatch(string what);
		if (mismatches < PRINT_LIMIT)
			$display("MISMATCH at %0t ns: %s", $time, what);
		mismatches++;
	endtask

	function automatic int active_parts();
		return (cfg_count > NUM_PARTS) ? NUM_PARTS : int'(cfg_count);
	endfunction

	// Returns the partition the current policy grants, or -1 when none fits.
	function automatic int pick_partition(logic [SIZE_W-1:0] req);
		int m;
		int pick;
		int first;
		int idx;
		m = active_parts();
		pick = -1;
		if (cfg_policy == POL_NEXT) begin
			first = (nf_ptr < m) ? int'(nf_ptr) : 0;
			for (int i = 0; i < m; i++) begin
				idx = (first + i) % m;
				if (!part_used[idx] && part_rem[idx] >= req)
					return idx;
			end
			return -1;
		end
		for (int i = 0; i < m; i++) begin
			if (part_used[i] || part_rem[i] < req)
				continue;
			if (pick < 0) begin
				pick = i;
				if (cfg_policy == POL_FIRST)
					return pick;
			end else if (cfg_policy == POL_BEST && part_rem[i] < part_rem[pick]) begin
				pick = i;
			end else if (cfg_policy == POL_WORST && part_rem[i] > part_rem[pick]) begin
				pick = i;
			end
		end
		return pick;
	endfunction

	// Applies one accepted item to the predicted state and queues its outcome.
	task automatic apply_command(op_t cmd, logic [3:0] idx, logic [SIZE_W-1:0] req);
		outcome_t res;
		int pick;
		int inner;
		int outer;
		res = '{default: '0};
		case (cmd)
			OP_LOAD: begin
				part_orig[idx] = req;
				part_rem[idx] = req;
			end
			OP_CLEAR: begin
				for (int i = 0; i < NUM_PARTS; i++) begin
					part_used[i] = 1'b0;
					part_rem[i] = part_orig[i];
				end
				nf_ptr = '0;
				fail_seen = 1'b0;
				fail_req = '0;
			end
			OP_ALLOC: begin
				pick = pick_partition(req);
				if (pick >= 0) begin
					part_used[pick] = 1'b1;
					part_rem[pick] = part_rem[pick] - req;
					if (cfg_policy == POL_NEXT)
						nf_ptr = 4'(pick);
					res.granted = 1'b1;
					res.block = 4'(pick);
				end else if (!fail_seen) begin
					fail_seen = 1'b1;
					fail_req = req;
				end
			end
			default: begin
				inner = 0;
				outer = 0;
				for (int i = 0; i < active_parts(); i++) begin
					if (part_used[i])
						inner += part_rem[i];
					else
						outer += part_rem[i];
				end
				res.internal = (inner > FRAG_MAX) ? FRAG_MAX : FRAG_W'(inner);
				res.external = (outer > FRAG_MAX) ? FRAG_MAX : FRAG_W'(outer);
				res.failed = fail_seen;
				res.failed_req = fail_seen ? fail_req : '0;
				res.fits_free = fail_seen && (outer >= int'(fail_req));
			end
		endcase
		outcome_q.push_back(res);
	endtask

	function automatic int pick_gap();
		int r;
		if (no_idle)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 40);
	endfunction

	// Drops start and puts junk on the item fields, which the block must ignore.
	task automatic release_start();
		if (start_held) begin
			start <= 1'b0;
			op <= 2'($urandom);
			block_index <= 4'($urandom);
			size <= 16'($urandom);
			start_held = 1'b0;
		end
	endtask

	// Start stays high when the next item follows at once, so it is never lowered and
	// raised within one time step.
	task automatic send_item(op_t cmd, logic [3:0] idx, logic [SIZE_W-1:0] req);
		int gap;
		start <= 1'b1;
		op <= cmd;
		block_index <= idx;
		size <= req;
		start_held = 1'b1;
		do @(posedge clk); while (busy !== 1'b0);
		apply_command(cmd, idx, req);
		items_sent++;
		gap = pick_gap();
		if (gap > 0) begin
			release_start();
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_idle();
		release_start();
		while (outcome_q.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic set_config(logic [4:0] count, policy_t pol);
		cfg_we <= 1'b1;
		cfg_index <= REG_BLOCKS_IN_USE;
		cfg_data <= count;
		@(posedge clk);
		cfg_index <= REG_POLICY;
		cfg_data <= CFG_DATA_W'(pol);
		@(posedge clk);
		cfg_we <= 1'b0;
		cfg_data <= CFG_DATA_W'($urandom);
		@(posedge clk);
		cfg_count = count;
		cfg_policy = pol;
	endtask

	task automatic test_load_first_parts();
		set_config(5'd4, POL_FIRST);
		send_item(OP_LOAD, 4'd0, 16'd100);
		send_item(OP_LOAD, 4'd1, 16'hFFFF);
		send_item(OP_LOAD, 4'd2, 16'd0);
		send_item(OP_LOAD, 4'd3, 16'd100);
	endtask

	task automatic test_first_fit();
		// A zero request fits any free partition; the last request fails on an empty one.
		send_item(OP_ALLOC, 4'd0, 16'd0);
		send_item(OP_ALLOC, 4'd0, 16'hFFFF);
		send_item(OP_ALLOC, 4'd0, 16'd50);
		send_item(OP_ALLOC, 4'd0, 16'd1);
		send_item(OP_REPORT, 4'd0, 16'd0);
	endtask

	task automatic test_best_fit();
		wait_idle();
		set_config(5'd4, POL_BEST);
		send_item(OP_CLEAR, 4'd0, 16'd0);
		send_item(OP_ALLOC, 4'd0, 16'd0);
		send_item(OP_ALLOC, 4'd0, 16'd100);
		send_item(OP_REPORT, 4'd0, 16'd0);
	endtask

	task automatic test_worst_fit();
		wait_idle();
		set_config(5'd4, POL_WORST);
		send_item(OP_CLEAR, 4'd0, 16'd0);
		send_item(OP_ALLOC, 4'd0, 16'd10);
		send_item(OP_ALLOC, 4'd0, 16'd100);
	endtask

	task automatic test_next_fit();
		wait_idle();
		set_config(5'd4, POL_NEXT);
		send_item(OP_CLEAR, 4'd0, 16'd0);
		send_item(OP_ALLOC, 4'd0, 16'hFFFF);
		// Fails although the free total equals the request.
		send_item(OP_ALLOC, 4'd0, 16'd200);
		send_item(OP_REPORT, 4'd0, 16'd0);
		// The kept pointer now lies beyond the single scanned partition.
		wait_idle();
		set_config(5'd1, POL_NEXT);
		send_item(OP_ALLOC, 4'd0, 16'd5);
	endtask

	task automatic test_load_keeps_used();
		send_item(OP_LOAD, 4'd0, 16'd7);
		send_item(OP_REPORT, 4'd0, 16'd0);
	endtask

	task automatic test_zero_parts();
		wait_idle();
		set_config(5'd0, POL_FIRST);
		send_item(OP_ALLOC, 4'd0, 16'd0);
		send_item(OP_REPORT, 4'd0, 16'd0);
	endtask

	function automatic logic [SIZE_W-1:0] alloc_request(logic [SIZE_W-1:0] span);
		int r;
		r = $urandom_range(0, 99);
		if (r < 10)
			return '0;
		if (r < 35)
			return part_rem[$urandom_range(0, NUM_PARTS - 1)];
		return SIZE_W'($urandom_range(0, span));
	endfunction

	// One phase: new settings, a few reloads, a clear, then a burst of requests.
	task automatic run_random_phase();
		logic [4:0]        count;
		logic [SIZE_W-1:0] span;
		int                r;
		int                n_alloc;
		wait_idle();
		r = $urandom_range(0, 99);
		if (r < 5)
			count = 5'd0;
		else if (r < 15)
			count = 5'($urandom_range(17, 31));
		else if (r < 45)
			count = 5'd16;
		else
			count = 5'($urandom_range(1, 15));
		set_config(count, policy_t'($urandom_range(0, 3)));
		no_idle = ($urandom_range(0, 3) == 0);
		span = ($urandom_range(0, 9) < 7) ? 16'd255 : 16'hFFFF;
		repeat ($urandom_range(0, 4))
			send_item(OP_LOAD, 4'($urandom), SIZE_W'($urandom_range(0, span)));
		send_item(OP_CLEAR, 4'($urandom), 16'($urandom));
		n_alloc = $urandom_range(4, 24);
		for (int k = 0; k < n_alloc; k++) begin
			r = $urandom_range(0, 99);
			if (r < 8)
				send_item(op_t'($urandom_range(0, 3)), 4'($urandom), 16'($urandom));
			else if (r < 18)
				send_item(OP_REPORT, 4'($urandom), 16'($urandom));
			else
				send_item(OP_ALLOC, 4'($urandom), alloc_request(span));
		end
		send_item(OP_REPORT, 4'($urandom), 16'($urandom));
	endtask

	task automatic test_random_traffic();
		wait_idle();
		set_config(5'd16, policy_t'($urandom_range(0, 3)));
		// Every partition gets a size before any wider scan can read it.
		for (int b = 0; b < NUM_PARTS; b++)
			send_item(OP_LOAD, 4'(b), 16'($urandom));
		while (items_sent < ITEM_TARGET)
			run_random_phase();
	endtask

	always @(posedge clk) begin : check_result
		outcome_t want;
		if (arst_n && done) begin
			if (outcome_q.size() == 0) begin
				report_mismatch("result arrived with no item outstanding");
			end else begin
				want = outcome_q.pop_front();
				if (granted !== want.granted)
					report_mismatch($sformatf("granted %0d, expected %0d",
						granted, want.granted));
				if (block_granted !== want.block)
					report_mismatch($sformatf("block_granted %0d, expected %0d",
						block_granted, want.block));
				if (internal_frag !== want.internal)
					report_mismatch($sformatf("internal_frag %0d, expected %0d",
						internal_frag, want.internal));
				if (external_frag !== want.external)
					report_mismatch($sformatf("external_frag %0d, expected %0d",
						external_frag, want.external));
				if (has_failed !== want.failed)
					report_mismatch($sformatf("has_failed %0d, expected %0d",
						has_failed, want.failed));
				if (failed_size !== want.failed_req)
					report_mismatch($sformatf("failed_size %0d, expected %0d",
						failed_size, want.failed_req));
				if (fits_despite_free !== want.fits_free)
					report_mismatch($sformatf("fits_despite_free %0d, expected %0d",
						fits_despite_free, want.fits_free));
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		for (int i = 0; i < NUM_PARTS; i++) begin
			part_orig[i] = '0;
			part_rem[i] = '0;
			part_used[i] = 1'b0;
		end
		nf_ptr = '0;
		fail_seen = 1'b0;
		fail_req = '0;
		cfg_count = BLOCKS_IN_USE_RESET;
		cfg_policy = POL_FIRST;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_load_first_parts();
		test_first_fit();
		test_best_fit();
		test_worst_fit();
		test_next_fit();
		test_load_keeps_used();
		test_zero_parts();
		test_random_traffic();

		wait_idle();
		repeat (NUM_PARTS + 4) @(posedge clk);
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
